// ===== sv/utf8_to_utf16_stream_decoder_defines.svh =====
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
// Depends on nothing; users must have clk and rst in scope.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define U8U16_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define U8U16_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("bad condition");
`else
`define U8U16_ASSERT(lbl, prop)
`define U8U16_NEVER(lbl, cond)
`endif
`endif

// ===== sv/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 stream decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u8u16_pkg;

  localparam int COUNT_W     = 16;
  localparam int UNIT_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic CFG_REPLACE_INVALID = 1'b0;
  localparam logic CFG_DEST_CAPACITY   = 1'b1;

  // Byte classification constants.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_TAG   = 8'hE0;
  localparam logic [UNIT_W-1:0] REPLACEMENT_UNIT = 16'h003F;

  // One decoded item as it travels from the front to the back: up to two
  // code units, optionally followed by the terminator with the counts.
  typedef struct packed {
    logic [1:0]         n_units;
    logic [UNIT_W-1:0]  unit0;
    logic [UNIT_W-1:0]  unit1;
    logic               term;
    logic               status;
    logic               saw_invalid;
    logic [COUNT_W-1:0] bytes_used;
    logic [COUNT_W-1:0] units_written;
  } cmd_t;

endpackage

// ===== sv/u8u16_front.sv =====
// Front end: configuration registers, per-string decode state and byte classification.
// Depends on u8u16_pkg and the shared assertion macros.
`include "utf8_to_utf16_stream_decoder_defines.svh"
module u8u16_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_acc,
  input  logic [7:0]           src_byte,
  input  logic                 end_of_source,
  output logic                 cmd_valid,
  output u8u16_pkg::cmd_t      cmd
);
  import u8u16_pkg::*;

  typedef struct packed {
    logic       emit;
    logic       stop;
    logic       err;
    logic       inv;
    logic [1:0] need;
  } lead_res_t;

  // Classify a byte taken as a lead byte.
  function automatic lead_res_t eval_lead(input logic [7:0] b, input logic no_more,
                                          input logic [COUNT_W-1:0] ucnt,
                                          input logic [15:0] cap, input logic allow);
    lead_res_t r;
    logic      cap_hit;
    r = '0;
    cap_hit = ({1'b0, ucnt} + 17'd1) >= {1'b0, cap};
    priority if (cap_hit || b == 8'h00) begin
      r.stop = 1'b1;
    end else if (b < ASCII_LIMIT) begin
      r.emit = 1'b1;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG && !no_more) begin
      r.need = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG && !no_more) begin
      r.need = 2'd2;
    end else begin
      r.inv = 1'b1;
      if (allow) begin
        r.emit = 1'b1;
      end else begin
        r.stop = 1'b1;
        r.err  = 1'b1;
      end
    end
    return r;
  endfunction

  logic               replace_invalid;
  logic [15:0]        dest_capacity;
  logic [7:0]         lead_byte, lead_byte_next;
  logic [7:0]         held0, held0_next;
  logic [1:0]         bytes_needed, bytes_needed_next;
  logic               bytes_held, bytes_held_next;
  logic [COUNT_W-1:0] unit_count, unit_count_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               finished, finished_next;
  logic               invalid_seen, invalid_seen_next;
  logic               stop_error, stop_error_next;
  logic [1:0]         n_units;
  logic [1:0]         add_bytes;
  logic [UNIT_W-1:0]  unit0, unit1;
  logic [COUNT_W:0]   byte_sum;
  lead_res_t          lr, lr_held;

  // Decode one byte against the current string state.
  always_comb begin
    lr      = eval_lead(src_byte, end_of_source, unit_count, dest_capacity, replace_invalid);
    lr_held = eval_lead(src_byte, 1'b1, unit_count + {{(COUNT_W-1){1'b0}}, 1'b1},
                        dest_capacity, replace_invalid);
    lead_byte_next    = lead_byte;
    held0_next        = held0;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    finished_next     = finished;
    invalid_seen_next = invalid_seen;
    stop_error_next   = stop_error;
    n_units           = 2'd0;
    add_bytes         = 2'd0;
    unit0             = '0;
    unit1             = '0;
    if (!finished) begin
      if (bytes_needed == 2'd0) begin
        if (lr.emit) begin
          n_units   = 2'd1;
          add_bytes = 2'd1;
          unit0     = lr.inv ? REPLACEMENT_UNIT : {8'h00, src_byte};
        end
        finished_next     = lr.stop;
        stop_error_next   = lr.err;
        invalid_seen_next = invalid_seen | lr.inv;
        if (lr.need != 2'd0) begin
          lead_byte_next    = src_byte;
          bytes_needed_next = lr.need;
          bytes_held_next   = 1'b0;
        end
      end else if (bytes_needed == 2'd2 && !bytes_held && !end_of_source) begin
        held0_next      = src_byte;
        bytes_held_next = 1'b1;
      end else if (bytes_needed == 2'd2 && !bytes_held) begin
        // Incomplete sequence at the end: the lead is invalid; with replacement on,
        // the byte after it is then handled as a lead.
        invalid_seen_next = 1'b1;
        bytes_needed_next = 2'd0;
        bytes_held_next   = 1'b0;
        if (replace_invalid) begin
          n_units   = 2'd1;
          add_bytes = 2'd1;
          unit0     = REPLACEMENT_UNIT;
          if (lr_held.emit) begin
            n_units   = 2'd2;
            add_bytes = 2'd2;
            unit1     = lr_held.inv ? REPLACEMENT_UNIT : {8'h00, src_byte};
          end
          finished_next   = lr_held.stop;
          stop_error_next = lr_held.err;
        end else begin
          finished_next   = 1'b1;
          stop_error_next = 1'b1;
        end
      end else begin
        // Sequence complete.
        n_units           = 2'd1;
        add_bytes         = bytes_needed + 2'd1;
        unit0             = (bytes_needed == 2'd1) ?
                            {5'b0, lead_byte[4:0], src_byte[5:0]} :
                            {lead_byte[3:0], held0[5:0], src_byte[5:0]};
        bytes_needed_next = 2'd0;
        bytes_held_next   = 1'b0;
      end
    end
    unit_count_next = unit_count + {{(COUNT_W-2){1'b0}}, n_units};
    byte_sum        = {1'b0, byte_count} + {{(COUNT_W-1){1'b0}}, add_bytes};
    byte_count_next = byte_sum[COUNT_W] ? {COUNT_W{1'b1}} : byte_sum[COUNT_W-1:0];
  end

  // Command toward the back end.
  always_comb begin
    cmd               = '0;
    cmd.n_units       = n_units;
    cmd.unit0         = unit0;
    cmd.unit1         = unit1;
    cmd.term          = end_of_source;
    if (end_of_source) begin
      cmd.status        = stop_error_next;
      cmd.saw_invalid   = invalid_seen_next;
      cmd.bytes_used    = byte_count_next;
      cmd.units_written = unit_count_next;
    end
    cmd_valid = in_acc && (n_units != 2'd0 || end_of_source);
  end

  // Configuration and string state.
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_invalid <= 1'b0;
      dest_capacity   <= 16'hFFFF;
      lead_byte       <= '0;
      held0           <= '0;
      bytes_needed    <= '0;
      bytes_held      <= 1'b0;
      unit_count      <= '0;
      byte_count      <= '0;
      finished        <= 1'b0;
      invalid_seen    <= 1'b0;
      stop_error      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_REPLACE_INVALID: replace_invalid <= cfg_wdata[0];
          CFG_DEST_CAPACITY:   dest_capacity   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (end_of_source) begin
          lead_byte    <= '0;
          held0        <= '0;
          bytes_needed <= '0;
          bytes_held   <= 1'b0;
          unit_count   <= '0;
          byte_count   <= '0;
          finished     <= 1'b0;
          invalid_seen <= 1'b0;
          stop_error   <= 1'b0;
        end else begin
          lead_byte    <= lead_byte_next;
          held0        <= held0_next;
          bytes_needed <= bytes_needed_next;
          bytes_held   <= bytes_held_next;
          unit_count   <= unit_count_next;
          byte_count   <= byte_count_next;
          finished     <= finished_next;
          invalid_seen <= invalid_seen_next;
          stop_error   <= stop_error_next;
        end
      end
    end
  end

  // A stopped string never waits on continuation bytes, and a held byte
  // only exists inside a three-byte sequence.
  `U8U16_ASSERT(a_fin_no_pending, finished |-> bytes_needed == 2'd0)
  `U8U16_ASSERT(a_held_in_seq3, bytes_held |-> bytes_needed == 2'd2)

endmodule

// ===== sv/u8u16_cmd_queue.sv =====
// Short command queue between the decoder front and the result back end.
// Depends on u8u16_pkg.
module u8u16_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8u16_pkg::cmd_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output u8u16_pkg::cmd_t  head
);
  import u8u16_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  // Status and handshake qualification.
  assign full    = (count == QUEUE_DEPTH[QPTR_W:0]);
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/u8u16_back.sv =====
// Back end: expands queued commands into result items in an output register, one per cycle unless the receiver stalls.
// Depends on u8u16_pkg and the shared assertion macros.
`include "utf8_to_utf16_stream_decoder_defines.svh"
module u8u16_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  u8u16_pkg::cmd_t  q_head,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [15:0]      code_unit,
  output logic             is_terminator,
  output logic             status,
  output logic             saw_invalid,
  output logic [15:0]      bytes_used,
  output logic [15:0]      units_written
);
  import u8u16_pkg::*;

  cmd_t              cur;
  logic              cur_valid;
  logic [1:0]        step;
  logic [1:0]        total;
  logic              out_valid;
  logic              out_free, emit_now, last_res, cur_done;
  logic [UNIT_W-1:0] res_unit;
  logic              res_term;

  // Pick the result at the current step of the current command.
  always_comb begin
    total    = cur.n_units + {1'b0, cur.term};
    out_free = !out_valid || pop;
    emit_now = cur_valid && out_free;
    last_res = (step == total - 2'd1);
    cur_done = emit_now && last_res;
    q_pop    = q_valid && (!cur_valid || cur_done);
    res_term = (step >= cur.n_units);
    res_unit = res_term ? '0 : ((step == 2'd0) ? cur.unit0 : cur.unit1);
  end

  // Current command, step counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid     <= 1'b1;
        code_unit     <= res_unit;
        is_terminator <= res_term;
        status        <= res_term & cur.status;
        saw_invalid   <= res_term & cur.saw_invalid;
        bytes_used    <= res_term ? cur.bytes_used : '0;
        units_written <= res_term ? cur.units_written : '0;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur       <= q_head;
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        step      <= '0;
      end else if (emit_now) begin
        step <= step + 2'd1;
      end
    end
  end

  assign empty = !out_valid;

  // Every command carries at least one result, and the step stays inside it.
  `U8U16_NEVER(a_cmd_nonempty, cur_valid && cur.n_units == 2'd0 && !cur.term)
  `U8U16_ASSERT(a_step_in_range, cur_valid |-> step < total)

endmodule

// ===== sv/utf8_to_utf16_stream_decoder.sv =====
// Top level of the streaming UTF-8 to UTF-16 (BMP) decoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_cmd_queue and u8u16_back.
//
// Usage: source bytes enter through a queue-style port: a byte is taken at a
// clock edge with push high and full low; end_of_source marks the last byte
// of a string. Results leave through a queue-style port: while empty is low
// the oldest result is on the result ports, and it is taken with pop high.
// Each string closes with a terminator result (is_terminator high, zero code
// unit) that carries status, saw_invalid, bytes_used and units_written.
// Configuration (replace_invalid at index 0, dest_capacity at index 1) is
// written through cfg_wr_en/cfg_addr/cfg_wdata while the block is idle.
// A result passes through the command queue, the current-command register and the
// output register. Input throughput is one byte per cycle while full is low; output
// is one result per cycle while pop is high, so a byte that yields two or three
// results holds the result side longer; a four-entry command queue absorbs the difference.
// When the receiver stalls, the queue fills and full rises; no result is lost.
// Reset (synchronous, active high) clears the string state, empties the queue,
// and sets replace_invalid to 0 and dest_capacity to 65535.
module utf8_to_utf16_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  src_byte,
  input  logic        end_of_source,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        is_terminator,
  output logic        status,
  output logic        saw_invalid,
  output logic [15:0] bytes_used,
  output logic [15:0] units_written
);
  import u8u16_pkg::*;

  logic in_acc;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  assign in_acc = push && !full;

  // Byte classification and string state.
  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_acc        (in_acc),
    .src_byte      (src_byte),
    .end_of_source (end_of_source),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  // Decoupling queue.
  u8u16_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data (cmd),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Result expansion and output register.
  u8u16_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .code_unit     (code_unit),
    .is_terminator (is_terminator),
    .status        (status),
    .saw_invalid   (saw_invalid),
    .bytes_used    (bytes_used),
    .units_written (units_written)
  );

endmodule
